>>> design/in_order_reply_reorder_buffer_assert.svh
// assertion macros for the in-order reply reorder buffer
`ifndef IN_ORDER_REPLY_REORDER_BUFFER_ASSERT_SVH
`define IN_ORDER_REPLY_REORDER_BUFFER_ASSERT_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define IORB_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("in_order_reply_reorder_buffer: check failed");

// next-cycle implication
`define IORB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("in_order_reply_reorder_buffer: check failed");

// invariant that holds at every edge
`define IORB_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("in_order_reply_reorder_buffer: check failed");

`endif

>>> design/iorb_pkg.sv
// shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps
package iorb_pkg;

   localparam int DEPTH         = 16;   // ring slots, a power of two
   localparam int TAG_BITS      = 16;
   localparam int SEQ_BITS      = 32;
   localparam int IDX_BITS      = $clog2(DEPTH);
   localparam int CNT_BITS      = $clog2(DEPTH + 1);
   localparam int MP_BITS       = 5;
   localparam int ENTRY_BITS    = TAG_BITS + 2;
   localparam int MAX_RESULTS   = DEPTH + 1;
   localparam int RES_BITS      = $clog2(MAX_RESULTS + 1);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_WORD_BITS = CSR_ADDR_BITS - 2;

   localparam logic [MP_BITS-1:0] MAX_PENDING_RESET = MP_BITS'(15);

   localparam logic [CSR_WORD_BITS-1:0] REG_MAX_PENDING = CSR_WORD_BITS'(0);

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_REPLY   = 1'b1;

   typedef enum logic [1:0] {
      KIND_SEQ      = 2'd0,
      KIND_SENT     = 2'd1,
      KIND_CALLBACK = 2'd2,
      KIND_ERROR    = 2'd3
   } kind_type;

   // what the decoded beat needs from the sequencer
   typedef enum logic [1:0] {
      DEC_NONE,
      DEC_EMIT,
      DEC_CHAIN
   } dec_type;

   typedef struct packed {
      logic accept;
      logic decode;
      logic drain;
      logic flush;
   } iorb_cmd_type;

   typedef struct packed {
      dec_type dec;
      logic    out_free;
      logic    hold_valid;
      logic    drain_blocked;
      logic    drain_more;
   } iorb_status_type;

endpackage

>>> design/in_order_reply_reorder_buffer.sv
// reorder buffer that puts replies back into request order
// order: a decoded result is loaded into the output register in the decode state that
// follows acceptance, once the output is free; a released run parks each beat in the held result first
// throughput: one beat in flight at a time; a reply that releases parked slots moves
// one slot per cycle through the drain sequencer, unless the output stalls
// reset: synchronous; clears counters, valid bits and the closed flag, max_pending
// returns to 15; slot contents are not cleared and there is no clearing pass
`timescale 1ns / 1ps
module in_order_reply_reorder_buffer import iorb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_operation,
   input  logic                     req_out_of_order,
   input  logic [SEQ_BITS-1:0]      req_reply_seq,
   input  logic [TAG_BITS-1:0]      req_reply_tag,
   input  logic                     req_has_payload,
   input  logic                     req_has_callback,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic [SEQ_BITS-1:0]      rsp_seq,
   output logic [TAG_BITS-1:0]      rsp_tag,
   output logic                     rsp_last,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   `include "in_order_reply_reorder_buffer_assert.svh"

   iorb_cmd_type        cmd;
   iorb_status_type     status;
   logic [MP_BITS-1:0]  max_pending_ff;
   logic [CSR_WORD_BITS-1:0] csr_word;
   logic                csr_write;

   assign csr_word   = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_word == REG_MAX_PENDING) ? CSR_DATA_BITS'(max_pending_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pending_ff <= MAX_PENDING_RESET;
      end else if (csr_write && csr_word == REG_MAX_PENDING) begin
         max_pending_ff <= csr_pwdata[MP_BITS-1:0];
      end
   end

   iorb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   iorb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .max_pending      (max_pending_ff),
      .req_operation    (req_operation),
      .req_out_of_order (req_out_of_order),
      .req_reply_seq    (req_reply_seq),
      .req_reply_tag    (req_reply_tag),
      .req_has_payload  (req_has_payload),
      .req_has_callback (req_has_callback),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_seq          (rsp_seq),
      .rsp_tag          (rsp_tag),
      .rsp_last         (rsp_last)
   );

   // one beat in flight at a time
   `IORB_ASSERT_NEXT(a_accept_then_busy, req_valid && !req_stall, req_stall)
   // a held result never survives into the next beat
   `IORB_ASSERT_IMPLIES(a_no_stale_hold, cmd.accept, !status.hold_valid)
   `IORB_ASSERT_ALWAYS(a_cmd_exclusive, $onehot0(cmd))

endmodule

>>> design/iorb_ctrl.sv
// sequencer: accept, decode, drain of a release chain, final flush
`timescale 1ns / 1ps
module iorb_ctrl import iorb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  iorb_status_type status,
   output iorb_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DRAIN,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!(status.dec == DEC_EMIT && !status.out_free)) begin
               cmd.decode = 1'b1;
               state_in   = (status.dec == DEC_CHAIN) ? ST_DRAIN : ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (!status.drain_blocked) begin
               cmd.drain = 1'b1;
               if (!status.drain_more) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!(status.hold_valid && !status.out_free)) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      stall_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

>>> design/iorb_datapath.sv
// counters, slot ring, held result and output register
`timescale 1ns / 1ps
module iorb_datapath import iorb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  iorb_cmd_type        cmd,
   output iorb_status_type     status,
   input  logic [MP_BITS-1:0]  max_pending,
   input  logic                req_operation,
   input  logic                req_out_of_order,
   input  logic [SEQ_BITS-1:0] req_reply_seq,
   input  logic [TAG_BITS-1:0] req_reply_tag,
   input  logic                req_has_payload,
   input  logic                req_has_callback,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [SEQ_BITS-1:0] rsp_seq,
   output logic [TAG_BITS-1:0] rsp_tag,
   output logic                rsp_last
);

   // current beat; during a drain the tag, payload and callback bits hold the slot being released
   logic                op_ff, ooo_ff, pay_ff, cb_ff;
   logic [SEQ_BITS-1:0] seq_ff;
   logic [TAG_BITS-1:0] tag_ff;

   logic [SEQ_BITS-1:0] next_arrival_ff, last_written_ff;
   logic                slot_valid_ff [DEPTH];
   logic [ENTRY_BITS-1:0] slot_entry_ff [DEPTH];
   logic [CNT_BITS-1:0] parked_ff;
   logic                closed_ff;
   logic [RES_BITS-1:0] n_ff;

   logic                hold_valid_ff;
   kind_type            hold_kind_ff;
   logic [SEQ_BITS-1:0] hold_seq_ff;
   logic [TAG_BITS-1:0] hold_tag_ff;

   logic                rsp_valid_ff, rsp_last_ff;
   kind_type            rsp_kind_ff;
   logic [SEQ_BITS-1:0] rsp_seq_ff;
   logic [TAG_BITS-1:0] rsp_tag_ff;

   logic [SEQ_BITS-1:0] lw_plus1, lw_plus2, win_off;
   logic                is_next, in_window, overflow, do_park, advance_arrival;
   dec_type             dec;
   kind_type            dec_kind;
   logic [SEQ_BITS-1:0] dec_seq;
   logic [TAG_BITS-1:0] dec_tag;
   logic [IDX_BITS-1:0] park_idx, next_idx;
   logic                emits, out_free, drain_more, push_hold;
   logic [RES_BITS-1:0] n_after;
   logic [ENTRY_BITS-1:0] next_entry;
   logic                out_load;
   kind_type            out_kind;
   logic [SEQ_BITS-1:0] out_seq;
   logic [TAG_BITS-1:0] out_tag;
   logic                out_last;

   assign lw_plus1  = last_written_ff + SEQ_BITS'(1);
   assign lw_plus2  = last_written_ff + SEQ_BITS'(2);
   assign win_off   = seq_ff - lw_plus2;
   assign is_next   = (seq_ff == lw_plus1);
   assign in_window = (win_off < SEQ_BITS'(DEPTH));
   assign overflow  = (32'(parked_ff) > 32'(max_pending)) || (32'(parked_ff) >= 32'(DEPTH));
   assign park_idx  = seq_ff[IDX_BITS-1:0];
   assign next_idx  = lw_plus2[IDX_BITS-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign do_park         = (op_ff == OP_REPLY) && !ooo_ff && !is_next && in_window;
   assign advance_arrival = (op_ff == OP_ARRIVAL) && !closed_ff && !ooo_ff;

   always_comb begin
      dec      = DEC_NONE;
      dec_kind = KIND_ERROR;
      dec_seq  = '0;
      dec_tag  = '0;
      if (op_ff == OP_ARRIVAL) begin
         if (closed_ff) begin
            dec = DEC_EMIT;
         end else if (!ooo_ff) begin
            dec = DEC_EMIT;
            if (!overflow) begin
               dec_kind = KIND_SEQ;
               dec_seq  = next_arrival_ff;
            end
         end
      end else if (ooo_ff) begin
         if (pay_ff) begin
            dec      = DEC_EMIT;
            dec_kind = KIND_SENT;
            dec_seq  = seq_ff;
            dec_tag  = tag_ff;
         end
      end else if (is_next) begin
         dec = DEC_CHAIN;
      end else if (!in_window) begin
         // refused: outside the parking window
         dec     = DEC_EMIT;
         dec_seq = seq_ff;
         dec_tag = tag_ff;
      end
   end

   // drain step
   assign emits      = pay_ff | cb_ff;
   assign n_after    = n_ff + RES_BITS'(emits);
   assign drain_more = slot_valid_ff[next_idx] && (n_after < RES_BITS'(MAX_RESULTS));
   assign next_entry = slot_entry_ff[next_idx];
   assign push_hold  = emits && hold_valid_ff;

   always_comb begin
      out_load = 1'b0;
      out_kind = hold_kind_ff;
      out_seq  = hold_seq_ff;
      out_tag  = hold_tag_ff;
      out_last = 1'b1;
      if (cmd.decode && dec == DEC_EMIT) begin
         out_load = 1'b1;
         out_kind = dec_kind;
         out_seq  = dec_seq;
         out_tag  = dec_tag;
      end else if (cmd.drain && push_hold) begin
         // a later beat follows, so this one is not last
         out_load = 1'b1;
         out_last = 1'b0;
      end else if (cmd.flush && hold_valid_ff) begin
         out_load = 1'b1;
      end
   end

   always_comb begin
      status.dec           = dec;
      status.out_free      = out_free;
      status.hold_valid    = hold_valid_ff;
      status.drain_blocked = push_hold && !out_free;
      status.drain_more    = drain_more;
   end

   // beat, slot payload, held result and output data, no reset
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_operation;
         ooo_ff <= req_out_of_order;
         seq_ff <= req_reply_seq;
         tag_ff <= req_reply_tag;
         pay_ff <= req_has_payload;
         cb_ff  <= req_has_callback;
      end else if (cmd.drain && drain_more) begin
         tag_ff <= next_entry[TAG_BITS-1:0];
         pay_ff <= next_entry[TAG_BITS];
         cb_ff  <= next_entry[TAG_BITS+1];
      end
      if (cmd.decode && do_park) begin
         slot_entry_ff[park_idx] <= {cb_ff, pay_ff, tag_ff};
      end
      if (cmd.drain && emits) begin
         hold_kind_ff <= pay_ff ? KIND_SENT : KIND_CALLBACK;
         hold_seq_ff  <= lw_plus1;
         hold_tag_ff  <= tag_ff;
      end
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_seq_ff  <= out_seq;
         rsp_tag_ff  <= out_tag;
         rsp_last_ff <= out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_arrival_ff <= SEQ_BITS'(1);
         last_written_ff <= '0;
         for (int i = 0; i < DEPTH; i++) begin
            slot_valid_ff[i] <= 1'b0;
         end
         parked_ff     <= '0;
         closed_ff     <= 1'b0;
         n_ff          <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.decode) begin
            n_ff <= '0;
            if (advance_arrival) begin
               next_arrival_ff <= next_arrival_ff + SEQ_BITS'(1);
               if (overflow) begin
                  closed_ff <= 1'b1;
               end
            end
            if (do_park && !slot_valid_ff[park_idx]) begin
               slot_valid_ff[park_idx] <= 1'b1;
               parked_ff               <= parked_ff + CNT_BITS'(1);
            end
         end
         if (cmd.drain) begin
            last_written_ff <= lw_plus1;
            n_ff            <= n_after;
            if (emits) begin
               hold_valid_ff <= 1'b1;
            end
            if (drain_more) begin
               slot_valid_ff[next_idx] <= 1'b0;
               parked_ff               <= parked_ff - CNT_BITS'(1);
            end
         end
         if (cmd.flush) begin
            hold_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_seq   = rsp_seq_ff;
   assign rsp_tag   = rsp_tag_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

>>> test/tb_top.sv
// self-checking testbench for the in-order reply reorder buffer
`timescale 1ns / 1ps
module tb_top;
   import iorb_pkg::*;

   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 2 * (MAX_RESULTS + 4);
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASES        = 5;
   localparam int CLOSE_PHASE   = PHASES - 1;
   localparam int DIRECTED_ROWS = 19;

   typedef struct packed {
      kind_type            kind;
      logic [SEQ_BITS-1:0] seq;
      logic [TAG_BITS-1:0] tag;
      logic                last;
   } rsp_beat_type;

   // one request beat, with a typed-in single expectation where fixed_exp is set
   typedef struct packed {
      logic                op;
      logic                ooo;
      logic [SEQ_BITS-1:0] seq;
      logic [TAG_BITS-1:0] tag;
      logic                pay;
      logic                cb;
      logic                fixed_exp;
      kind_type            ekind;
      logic [SEQ_BITS-1:0] eseq;
      logic [TAG_BITS-1:0] etag;
   } req_item_type;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_operation    = OP_ARRIVAL;
   logic                     req_out_of_order = 1'b0;
   logic [SEQ_BITS-1:0]      req_reply_seq    = '0;
   logic [TAG_BITS-1:0]      req_reply_tag    = '0;
   logic                     req_has_payload  = 1'b0;
   logic                     req_has_callback = 1'b0;
   logic                     rsp_stall        = 1'b0;
   logic                     csr_psel         = 1'b0;
   logic                     csr_penable      = 1'b0;
   logic                     csr_pwrite       = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr        = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata       = '0;
   logic                     req_stall;
   logic                     rsp_valid;
   logic [1:0]               rsp_kind;
   logic [SEQ_BITS-1:0]      rsp_seq;
   logic [TAG_BITS-1:0]      rsp_tag;
   logic                     rsp_last;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // predictor copy of the block state
   bit [SEQ_BITS-1:0]   arrival_next;
   bit [SEQ_BITS-1:0]   written_last;
   bit                  slot_held [DEPTH];
   bit [ENTRY_BITS-1:0] slot_data [DEPTH];
   int                  held_count;
   bit                  chan_closed;
   bit [MP_BITS-1:0]    pend_limit;

   rsp_beat_type due_beats[$];
   rsp_beat_type step_beats[$];
   req_item_type directed_rows [DIRECTED_ROWS];

   int sender_pct = 0;
   int recv_pct   = 0;
   int cycles     = 0;
   int mismatches = 0;
   int beats_checked = 0;
   int items_sent    = 0;
   int settings_used = 1;
   int longest_run   = 0;

   in_order_reply_reorder_buffer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_out_of_order (req_out_of_order),
      .req_reply_seq    (req_reply_seq),
      .req_reply_tag    (req_reply_tag),
      .req_has_payload  (req_has_payload),
      .req_has_callback (req_has_callback),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_seq          (rsp_seq),
      .rsp_tag          (rsp_tag),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   always @(posedge clock) begin
      rsp_stall <= (recv_pct > 0) && ($urandom_range(0, 99) < recv_pct);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch_rsp
      rsp_beat_type beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (due_beats.size() == 0) begin
            report_mismatch("result beat with nothing due, seq", rsp_seq, '0);
         end else begin
            beat = due_beats.pop_front();
            if (rsp_kind !== beat.kind) report_mismatch("kind", 32'(rsp_kind), 32'(beat.kind));
            if (rsp_seq !== beat.seq) report_mismatch("seq", rsp_seq, beat.seq);
            if (rsp_tag !== beat.tag) report_mismatch("tag", 32'(rsp_tag), 32'(beat.tag));
            if (rsp_last !== beat.last) report_mismatch("last", 32'(rsp_last), 32'(beat.last));
         end
      end
   end

   function automatic void add_beat(input kind_type k, input bit [SEQ_BITS-1:0] s,
                                    input bit [TAG_BITS-1:0] t);
      step_beats.push_back('{kind: k, seq: s, tag: t, last: 1'b0});
   endfunction

   // works out the beats one accepted request causes and moves the state on
   task automatic reorder_step(input req_item_type it);
      bit [SEQ_BITS-1:0]   cur;
      bit [SEQ_BITS-1:0]   offset;
      bit [TAG_BITS-1:0]   rtag;
      bit [ENTRY_BITS-1:0] ent;
      bit                  pay;
      bit                  cb;
      bit                  more;
      int                  idx;
      rsp_beat_type        tail;
      step_beats.delete();
      rtag = it.tag;
      pay  = it.pay;
      cb   = it.cb;
      if (it.op == OP_ARRIVAL) begin
         if (chan_closed) begin
            add_beat(KIND_ERROR, '0, '0);
         end else if (!it.ooo) begin
            if (held_count > pend_limit || held_count >= DEPTH) begin
               chan_closed = 1'b1;
               add_beat(KIND_ERROR, '0, '0);
            end else begin
               add_beat(KIND_SEQ, arrival_next, '0);
            end
            arrival_next = arrival_next + 1;
         end
      end else if (it.ooo) begin
         if (pay) add_beat(KIND_SENT, it.seq, rtag);
      end else if (it.seq != written_last + 1) begin
         offset = it.seq - written_last - 2;
         if (offset < DEPTH) begin
            idx = it.seq % DEPTH;
            if (!slot_held[idx]) begin
               slot_held[idx] = 1'b1;
               held_count++;
            end
            slot_data[idx] = {cb, pay, rtag};
         end else begin
            add_beat(KIND_ERROR, it.seq, rtag);
         end
      end else begin
         more = 1'b1;
         while (more) begin
            cur = written_last + 1;
            if (pay) add_beat(KIND_SENT, cur, rtag);
            else if (cb) add_beat(KIND_CALLBACK, cur, rtag);
            written_last = cur;
            idx = (written_last + 1) % DEPTH;
            if (!slot_held[idx] || step_beats.size() >= MAX_RESULTS) begin
               more = 1'b0;
            end else begin
               ent = slot_data[idx];
               slot_held[idx] = 1'b0;
               held_count--;
               rtag = ent[TAG_BITS-1:0];
               pay  = ent[TAG_BITS];
               cb   = ent[TAG_BITS+1];
            end
         end
      end
      if (step_beats.size() > 0) begin
         tail = step_beats.pop_back();
         tail.last = 1'b1;
         step_beats.push_back(tail);
      end
      if (step_beats.size() > longest_run) longest_run = step_beats.size();
   endtask

   task automatic send_item(input req_item_type it);
      if (sender_pct > 0 && $urandom_range(0, 99) < sender_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= it.op;
      req_out_of_order <= it.ooo;
      req_reply_seq    <= it.seq;
      req_reply_tag    <= it.tag;
      req_has_payload  <= it.pay;
      req_has_callback <= it.cb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      reorder_step(it);
      if (it.fixed_exp) begin
         due_beats.push_back('{kind: it.ekind, seq: it.eseq, tag: it.etag, last: 1'b1});
      end else begin
         foreach (step_beats[i]) due_beats.push_back(step_beats[i]);
      end
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_beats.size() != 0) @(posedge clock);
   endtask

   task automatic write_max_pending(input bit [MP_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({REG_MAX_PENDING, 2'b00});
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      pend_limit = value;
      @(posedge clock);
      if (csr_prdata !== CSR_DATA_BITS'(value)) begin
         report_mismatch("max_pending read back", csr_prdata, CSR_DATA_BITS'(value));
      end
   endtask

   // half are replies at the head or inside the window so chains build up; the rest is arrivals and noise
   function automatic req_item_type random_item(input bit may_close);
      req_item_type it;
      int           pick;
      it     = '0;
      it.seq = $urandom;
      it.tag = TAG_BITS'($urandom_range(0, 65535));
      it.pay = 1'($urandom_range(0, 1));
      it.cb  = 1'($urandom_range(0, 1));
      pick   = $urandom_range(0, 99);
      if (pick < 28) begin
         it.op  = OP_ARRIVAL;
         it.ooo = ($urandom_range(0, 9) == 0);
         if (!it.ooo && !may_close && !chan_closed &&
             (held_count > pend_limit || held_count >= DEPTH)) begin
            // would close the channel too early, release the head instead
            it.op  = OP_REPLY;
            it.seq = written_last + 1;
         end
      end else if (pick < 78) begin
         it.op  = OP_REPLY;
         it.ooo = 1'b0;
         it.pay = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0) it.seq = written_last + 1;
         else it.seq = written_last + 2 + $urandom_range(0, DEPTH - 1);
      end else if (pick < 90) begin
         it.op  = OP_REPLY;
         it.ooo = 1'b1;
      end else begin
         it.op  = OP_REPLY;
         it.ooo = 1'b0;
         case ($urandom_range(0, 2))
            0: it.seq = written_last;
            1: it.seq = written_last + DEPTH + 2;
            default: ;
         endcase
      end
      return it;
   endfunction

   initial begin : stimulus
      int           limits [PHASES];
      int           s_pcts [PHASES];
      int           r_pcts [PHASES];
      int           quotas [PHASES];
      int           counted;
      req_item_type it;

      limits = '{16, 0, -1, 15, 16};
      s_pcts = '{0, 55, 0, 28, 28};
      r_pcts = '{0, 0, 55, 28, 28};
      quotas = '{65, 65, 65, 65, 80};

      // op, ooo, seq, tag, pay, cb, fixed, kind, seq, tag
      directed_rows = '{
         '{OP_ARRIVAL, 1'b0, 32'h0,        16'h0,    1'b0, 1'b0, 1'b1, KIND_SEQ,   32'd1,
           16'h0},
         '{OP_ARRIVAL, 1'b1, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, KIND_SEQ,   32'h0,
           16'h0},
         '{OP_ARRIVAL, 1'b0, 32'h0,        16'h0,    1'b0, 1'b0, 1'b1, KIND_SEQ,   32'd2,
           16'h0},
         '{OP_REPLY,   1'b1, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, KIND_SENT,
           32'hFFFFFFFF, 16'hFFFF},
         '{OP_REPLY,   1'b1, 32'h0,        16'h0,    1'b1, 1'b0, 1'b1, KIND_SENT,  32'h0,
           16'h0},
         '{OP_REPLY,   1'b1, 32'h5A5A,     16'h1234, 1'b0, 1'b1, 1'b0, KIND_SEQ,   32'h0,
           16'h0},
         '{OP_REPLY,   1'b0, 32'h0,        16'hFFFF, 1'b1, 1'b0, 1'b1, KIND_ERROR, 32'h0,
           16'hFFFF},
         '{OP_REPLY,   1'b0, 32'hFFFFFFFF, 16'h0,    1'b1, 1'b1, 1'b1, KIND_ERROR,
           32'hFFFFFFFF, 16'h0},
         '{OP_REPLY,   1'b0, 32'd18,       16'h00FF, 1'b1, 1'b0, 1'b1, KIND_ERROR, 32'd18,
           16'h00FF},
         '{OP_REPLY,   1'b0, 32'd17,       16'hABCD, 1'b1, 1'b0, 1'b0, KIND_SEQ,   32'h0,
           16'h0},
         '{OP_REPLY,   1'b0, 32'd3,        16'h1111, 1'b1, 1'b0, 1'b0, KIND_SEQ,   32'h0,
           16'h0},
         '{OP_REPLY,   1'b0, 32'd3,        16'h2222, 1'b1, 1'b1, 1'b0, KIND_SEQ,   32'h0,
           16'h0},
         '{OP_REPLY,   1'b0, 32'd2,        16'h3333, 1'b0, 1'b1, 1'b0, KIND_SEQ,   32'h0,
           16'h0},
         '{OP_REPLY,   1'b0, 32'd4,        16'h4444, 1'b0, 1'b0, 1'b0, KIND_SEQ,   32'h0,
           16'h0},
         '{OP_REPLY,   1'b0, 32'd5,        16'h5555, 1'b1, 1'b0, 1'b0, KIND_SEQ,   32'h0,
           16'h0},
         '{OP_REPLY,   1'b0, 32'd1,        16'h6666, 1'b1, 1'b0, 1'b0, KIND_SEQ,   32'h0,
           16'h0},
         '{OP_REPLY,   1'b0, 32'd6,        16'h7777, 1'b0, 1'b0, 1'b0, KIND_SEQ,   32'h0,
           16'h0},
         '{OP_REPLY,   1'b0, 32'd7,        16'h8888, 1'b0, 1'b1, 1'b1, KIND_CALLBACK,
           32'd7, 16'h8888},
         '{OP_ARRIVAL, 1'b0, 32'h0,        16'h0,    1'b0, 1'b0, 1'b1, KIND_SEQ,   32'd3,
           16'h0}
      };

      arrival_next = 1;
      written_last = 0;
      held_count   = 0;
      chan_closed  = 1'b0;
      pend_limit   = MAX_PENDING_RESET;
      foreach (slot_held[i]) slot_held[i] = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_item(directed_rows[i]);

      for (int p = 0; p < PHASES; p++) begin
         hold_until_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         write_max_pending((limits[p] < 0) ? MP_BITS'($urandom_range(1, 14))
                                           : MP_BITS'(limits[p]));
         settings_used++;
         sender_pct = s_pcts[p];
         recv_pct   = r_pcts[p];

         if (p == CLOSE_PHASE) begin
            // fill every slot of the window, overflow on the full ring, then drain
            for (int k = 2; k <= DEPTH + 1; k++) begin
               it     = '0;
               it.op  = OP_REPLY;
               it.seq = written_last + k;
               it.tag = TAG_BITS'($urandom_range(0, 65535));
               it.pay = 1'b1;
               it.cb  = 1'($urandom_range(0, 1));
               send_item(it);
            end
            it    = '0;
            it.op = OP_ARRIVAL;
            send_item(it);
            it.ooo = 1'b1;
            send_item(it);
            it     = '0;
            it.op  = OP_REPLY;
            it.seq = written_last + 1;
            it.tag = TAG_BITS'($urandom_range(0, 65535));
            it.pay = 1'b1;
            send_item(it);
         end

         counted = 0;
         while (counted < quotas[p]) begin
            if (counted == quotas[p] / 2) hold_until_drained();
            it = random_item(p == CLOSE_PHASE);
            if (!((it.op == OP_ARRIVAL && it.ooo && !chan_closed) ||
                  (it.op == OP_REPLY && it.ooo && !it.pay))) counted++;
            send_item(it);
         end
      end

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d request and reply beats under %0d limits, %0d results checked",
               items_sent, settings_used, beats_checked);
      $display("longest release run %0d beats, channel closed at end: %0d",
               longest_run, chan_closed);
      if (mismatches == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) @(posedge clock);
      $display("tb_top failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/iorb_pkg.sv
design/iorb_ctrl.sv
design/iorb_datapath.sv
design/in_order_reply_reorder_buffer.sv
test/tb_top.sv
